FILE: rtl/core/brbw_pkg.sv
package brbw_pkg;

  // Q1.15 value of one.
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Quotient bits produced by the ramp divider, one per stage.
  localparam int DIV_STEPS = 15;

  // Register stages: projection 2, ramp setup 1, divider, weight product 6.
  localparam int LATENCY = 3 + DIV_STEPS + 6;

  // Rounding constant for the Q.22 to Q8.8 projection.
  localparam logic signed [33:0] ROUND_Q22 = 34'sd8192;

  // Register map, by index.
  typedef enum logic [2:0] {
    REG_AXIS_ONE_DIR    = 3'd0,
    REG_AXIS_TWO_DIR    = 3'd1,
    REG_AXIS_THREE_DIR  = 3'd2,
    REG_AXIS_ONE_BOUNDS = 3'd3,
    REG_AXIS_TWO_BOUNDS = 3'd4,
    REG_AXIS_THREE_BOUNDS = 3'd5
  } reg_idx_t;

  localparam logic [63:0] DIR_ONE_RESET   = 64'h0000_0000_0000_4000;
  localparam logic [63:0] DIR_TWO_RESET   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] DIR_THREE_RESET = 64'h0000_4000_0000_0000;
  localparam logic [63:0] BOUNDS_RESET    = 64'h7FFF_7FFF_8001_8000;

  // One ramp handed to the divider: either a fixed value or an/ad.
  typedef struct packed {
    logic        fixed;
    logic        one;
    logic [15:0] an;
    logic [15:0] ad;
  } ramp_op_t;

endpackage

FILE: rtl/core/box_region_blend_weight.sv
// Blend weight of a mesh point against a soft box in a rotated frame.
// Accepts one point per cycle while the output is not stalled, and returns
// one weight per point, in order. The depth comes from the projection and
// ramp setup stages, then a 15-stage pipelined divider per ramp (six in
// parallel) and six chained weight multipliers, one per stage. The whole
// pipeline holds when the output is full and not taken, so s_tready is high
// whenever the output slot is empty or being taken. Registers lie at byte
// address 8*i and should be written only while the pipeline is empty.
module box_region_blend_weight (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_x, point_y, point_z, initial_weight
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // blended_weight
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import brbw_pkg::*;

  logic [63:0]        dir [3];
  logic [63:0]        bnd [3];
  logic [LATENCY-1:0] vld;
  logic               adv;
  logic [15:0]        wd  [3+DIV_STEPS];
  logic [15:0]        w_in;
  logic signed [15:0] s   [3];
  ramp_op_t           op  [6];
  logic [15:0]        ramp [6];
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir[0] <= DIR_ONE_RESET;
      dir[1] <= DIR_TWO_RESET;
      dir[2] <= DIR_THREE_RESET;
      bnd[0] <= BOUNDS_RESET;
      bnd[1] <= BOUNDS_RESET;
      bnd[2] <= BOUNDS_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_AXIS_ONE_DIR:      dir[0] <= pwdata;
        REG_AXIS_TWO_DIR:      dir[1] <= pwdata;
        REG_AXIS_THREE_DIR:    dir[2] <= pwdata;
        REG_AXIS_ONE_BOUNDS:   bnd[0] <= pwdata;
        REG_AXIS_TWO_BOUNDS:   bnd[1] <= pwdata;
        REG_AXIS_THREE_BOUNDS: bnd[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (idx)
      REG_AXIS_ONE_DIR:      prdata = dir[0];
      REG_AXIS_TWO_DIR:      prdata = dir[1];
      REG_AXIS_THREE_DIR:    prdata = dir[2];
      REG_AXIS_ONE_BOUNDS:   prdata = bnd[0];
      REG_AXIS_TWO_BOUNDS:   prdata = bnd[1];
      REG_AXIS_THREE_BOUNDS: prdata = bnd[2];
      default:               prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output slot is free or being taken.
  assign adv      = !vld[LATENCY-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], s_tvalid};
    end
  end

  // Incoming weight, saturated to one, delayed to meet the ramps.
  assign w_in = (s_tdata[63:48] > ONE_Q15) ? ONE_Q15 : s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (adv) begin
      wd[0] <= w_in;
      for (int i = 1; i < 3 + DIV_STEPS; i++) begin
        wd[i] <= wd[i-1];
      end
    end
  end

  brbw_proj u_proj (
    .clk (clk),
    .adv (adv),
    .px  (s_tdata[15:0]),
    .py  (s_tdata[31:16]),
    .pz  (s_tdata[47:32]),
    .dir (dir),
    .s   (s)
  );

  brbw_ramp u_ramp (
    .clk (clk),
    .adv (adv),
    .s   (s),
    .bnd (bnd),
    .op  (op)
  );

  for (genvar j = 0; j < 6; j++) begin : g_div
    brbw_div u_div (
      .clk  (clk),
      .adv  (adv),
      .op   (op[j]),
      .ramp (ramp[j])
    );
  end

  brbw_wmul u_wmul (
    .clk   (clk),
    .adv   (adv),
    .w_in  (wd[2+DIV_STEPS]),
    .ramp  (ramp),
    .w_out (m_tdata)
  );

endmodule

FILE: rtl/core/brbw_proj.sv
module brbw_proj (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] px,
  input  logic signed [15:0] py,
  input  logic signed [15:0] pz,
  input  logic [63:0]        dir [3],
  output logic signed [15:0] s   [3]
);
  import brbw_pkg::*;

  logic signed [31:0] prod [3][3];

  // First stage: the nine component products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        prod[a][0] <= 32'(px) * 32'($signed(dir[a][15:0]));
        prod[a][1] <= 32'(py) * 32'($signed(dir[a][31:16]));
        prod[a][2] <= 32'(pz) * 32'($signed(dir[a][47:32]));
      end
    end
  end

  // Second stage: sum, round half up to Q8.8 and saturate.
  always_ff @(posedge clk) begin
    logic signed [33:0] sum;
    logic signed [19:0] sh;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        sum = 34'(prod[a][0]) + 34'(prod[a][1]) + 34'(prod[a][2]) + ROUND_Q22;
        sh  = sum[33:14];
        if (sh > 20'sd32767) begin
          s[a] <= 16'sh7FFF;
        end else if (sh < -20'sd32768) begin
          s[a] <= 16'sh8000;
        end else begin
          s[a] <= sh[15:0];
        end
      end
    end
  end

endmodule

FILE: rtl/core/brbw_ramp.sv
module brbw_ramp (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] s   [3],
  input  logic [63:0]        bnd [3],
  output brbw_pkg::ramp_op_t op  [6]
);
  import brbw_pkg::*;

  // Turns num/den into a divider operand, settling the trivial cases here.
  function automatic ramp_op_t make_op(logic signed [16:0] num, logic signed [16:0] den);
    ramp_op_t o;
    logic [16:0] an;
    logic [16:0] ad;
    an = num[16] ? 17'(-num) : num;
    ad = den[16] ? 17'(-den) : den;
    o.fixed = 1'b0;
    o.one   = 1'b0;
    o.an    = an[15:0];
    o.ad    = ad[15:0];
    if (num == 17'sd0 || (num[16] != den[16])) begin
      o.fixed = 1'b1;
    end else if (an >= ad) begin
      o.fixed = 1'b1;
      o.one   = 1'b1;
    end
    return o;
  endfunction

  // Rising ramp of axis a sits at 2a, falling ramp at 2a+1.
  always_ff @(posedge clk) begin
    logic signed [15:0] lo, li, ri, ro;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        lo = bnd[a][15:0];
        li = bnd[a][31:16];
        ri = bnd[a][47:32];
        ro = bnd[a][63:48];
        if (li == lo) begin
          op[2*a] <= '{fixed: 1'b1, one: (s[a] >= li), an: '0, ad: '0};
        end else begin
          op[2*a] <= make_op(17'(s[a]) - 17'(lo), 17'(li) - 17'(lo));
        end
        if (ro == ri) begin
          op[2*a+1] <= '{fixed: 1'b1, one: (s[a] <= ri), an: '0, ad: '0};
        end else begin
          op[2*a+1] <= make_op(17'(ro) - 17'(s[a]), 17'(ro) - 17'(ri));
        end
      end
    end
  end

endmodule

FILE: rtl/core/brbw_div.sv
module brbw_div (
  input  logic               clk,
  input  logic               adv,
  input  brbw_pkg::ramp_op_t op,
  output logic [15:0]        ramp
);
  import brbw_pkg::*;

  // Restoring division, one quotient bit per stage; remainder stays below ad.
  logic [15:0]          rem [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo [DIV_STEPS+1];
  logic [15:0]          ad  [DIV_STEPS+1];
  logic                 fix [DIV_STEPS+1];
  logic                 one [DIV_STEPS+1];

  assign rem[0] = op.an;
  assign quo[0] = '0;
  assign ad[0]  = op.ad;
  assign fix[0] = op.fixed;
  assign one[0] = op.one;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [16:0] r2;
    logic        ge;
    logic [16:0] rn;
    always_comb begin
      r2 = {rem[g], 1'b0};
      ge = r2 >= {1'b0, ad[g]};
      rn = ge ? r2 - {1'b0, ad[g]} : r2;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[g+1] <= rn[15:0];
        quo[g+1] <= {quo[g][DIV_STEPS-2:0], ge};
        ad[g+1]  <= ad[g];
        fix[g+1] <= fix[g];
        one[g+1] <= one[g];
      end
    end
  end

  // Fixed cases bypass the quotient.
  assign ramp = fix[DIV_STEPS] ? (one[DIV_STEPS] ? ONE_Q15 : 16'd0)
                               : {1'b0, quo[DIV_STEPS]};

endmodule

FILE: rtl/core/brbw_wmul.sv
module brbw_wmul (
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] w_in,
  input  logic [15:0] ramp  [6],
  output logic [15:0] w_out
);
  import brbw_pkg::*;

  logic [15:0] w  [7];
  logic [15:0] rp [6][6];

  assign w[0]  = w_in;
  assign rp[0] = ramp;
  assign w_out = w[6];

  // One truncating Q1.15 multiply per stage, ramps carried alongside.
  for (genvar k = 0; k < 6; k++) begin : g_mul
    logic [31:0] prod;
    assign prod = 32'(w[k]) * 32'(rp[k][k]);
    always_ff @(posedge clk) begin
      if (adv) begin
        w[k+1] <= prod[30:15];
      end
    end
    // Later stages still need the remaining ramps.
    if (k < 5) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) begin
          rp[k+1] <= rp[k];
        end
      end
    end
  end

endmodule

FILE: rtl/core/brbw_checker.sv
module brbw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        pready
);
  import brbw_pkg::*;

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input side takes data exactly when the output slot can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output slot");

  // The weight never exceeds one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= ONE_Q15)
    else $error("weight above one");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("config port not ready");

endmodule

bind box_region_blend_weight brbw_checker u_brbw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

import brbw_pkg::*;

// Expected blend weights, oldest first, with a mismatch count.
class blend_scoreboard;
  logic [15:0] weights_due[$];
  int          errors;

  function void note_point(logic [15:0] w);
    weights_due.push_back(w);
  endfunction

  // Returns a short text on mismatch, empty when the result is as expected.
  function string check_weight(logic [15:0] got);
    logic [15:0] want;
    if (weights_due.size() == 0) begin
      return $sformatf("result %0d with nothing outstanding", got);
    end
    want = weights_due.pop_front();
    if (got !== want) begin
      return $sformatf("blended_weight got %0d want %0d", got, want);
    end
    return "";
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  blend_scoreboard sb;
  logic [63:0]     dir_regs[3];
  logic [63:0]     bound_regs[3];
  int              sent;
  int              taken;
  bit              quiet_mode;

  box_region_blend_weight dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout guard.
  initial begin
    #5ms;
    $display("[box_region_blend_weight] ERROR");
    $finish;
  end

  task automatic report(input string msg);
    sb.errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int signed s16(logic [63:0] word, int slot);
    logic signed [15:0] v;
    v = word[16*slot +: 16];
    return v;
  endfunction

  // Point projected onto one axis, rounded half up and saturated to Q8.8.
  function automatic int signed axis_coord(logic [63:0] pt, logic [63:0] dir);
    longint signed acc;
    longint signed q;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += longint'(s16(pt, i)) * longint'(s16(dir, i));
    q = (acc + 8192) >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic int unsigned ramp_fraction(int signed num, int signed den);
    int unsigned an;
    int unsigned ad;
    if (num == 0 || ((num < 0) != (den < 0))) return 0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return 32768;
    return (an << 15) / ad;
  endfunction

  function automatic logic [15:0] blend_of(logic [63:0] pt);
    int unsigned w;
    int unsigned r;
    int signed   p;
    int signed   lo, li, ri, ro;
    w = 32'(pt[63:48]);
    if (w > 32768) w = 32768;
    for (int a = 0; a < 3; a++) begin
      p  = axis_coord(pt, dir_regs[a]);
      lo = s16(bound_regs[a], 0);
      li = s16(bound_regs[a], 1);
      ri = s16(bound_regs[a], 2);
      ro = s16(bound_regs[a], 3);
      // A zero-width ramp is a step at the inner bound.
      r = (li == lo) ? ((p >= li) ? 32768 : 0) : ramp_fraction(p - lo, li - lo);
      w = (w * r) >> 15;
      r = (ro == ri) ? ((p <= ri) ? 32768 : 0) : ramp_fraction(ro - p, ro - ri);
      w = (w * r) >> 15;
    end
    return w[15:0];
  endfunction

  function automatic bit idle_now();
    return !quiet_mode && ($urandom_range(99) < 16);
  endfunction

  // Register write: setup cycle then access cycle.
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx <= REG_AXIS_THREE_DIR) dir_regs[idx] = val;
    else bound_regs[idx - REG_AXIS_ONE_BOUNDS] = val;
  endtask

  task automatic send_point(input logic [63:0] pt);
    while (idle_now()) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    s_tvalid = 1'b1;
    s_tdata  = pt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_point(blend_of(pt));
    sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.weights_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_bounds(int lo, int li, int ri, int ro);
    return {ro[15:0], ri[15:0], li[15:0], lo[15:0]};
  endfunction

  function automatic logic [63:0] random_dir();
    logic [63:0] d;
    d = {$urandom, $urandom};
    // Mostly a first component anywhere in [-1, 1) with small tilt, sometimes raw bits.
    if ($urandom_range(3) != 0) begin
      d[15:0]  = 16'($urandom_range(32767) - 16384);
      d[31:16] = 16'($urandom_range(8191) - 4096);
      d[47:32] = 16'($urandom_range(8191) - 4096);
    end
    return d;
  endfunction

  function automatic logic [63:0] random_bounds();
    int lo, li, ri, ro;
    if ($urandom_range(4) == 0) return {$urandom, $urandom};
    lo = $urandom_range(4000) - 6000;
    li = lo + $urandom_range(3000);
    ri = $urandom_range(4000) - 1000;
    ro = ri + $urandom_range(3000);
    return pack_bounds(lo, li, ri, ro);
  endfunction

  function automatic logic [63:0] random_point();
    logic [63:0] pt;
    pt = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      pt[15:0]  = 16'($urandom_range(16000) - 8000);
      pt[31:16] = 16'($urandom_range(16000) - 8000);
      pt[47:32] = 16'($urandom_range(16000) - 8000);
      pt[63:48] = 16'($urandom_range(32768));
    end
    return pt;
  endfunction

  // Result side with random stalls; the check runs at every output transfer.
  initial begin
    string msg;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      m_tready = !idle_now();
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        taken++;
        msg = sb.check_weight(m_tdata);
        if (msg != "") report(msg);
      end
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    sent = 0; taken = 0; quiet_mode = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    dir_regs[0] = DIR_ONE_RESET; dir_regs[1] = DIR_TWO_RESET;
    dir_regs[2] = DIR_THREE_RESET;
    for (int i = 0; i < 3; i++) bound_regs[i] = BOUNDS_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed points under reset settings: field extremes and weight above one.
    send_point({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    send_point({16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
    send_point({16'h0000, 16'h8000, 16'h8000, 16'h8000});
    send_point({16'h4000, 16'h7FFF, 16'h8000, 16'hFFFF});
    send_point({16'h8001, 16'h0100, 16'hFF00, 16'h0001});
    drain();

    // Soft box with ramps, zero-width steps and inverted bounds.
    write_reg(REG_AXIS_ONE_BOUNDS,   pack_bounds(-512, -256, 256, 512));
    write_reg(REG_AXIS_TWO_BOUNDS,   pack_bounds(-256, -256, 256, 256));
    write_reg(REG_AXIS_THREE_BOUNDS, pack_bounds(512, -512, 512, -512));
    write_reg(REG_AXIS_ONE_DIR, 64'h0000_0000_2D41_2D41);
    write_reg(REG_AXIS_TWO_DIR, 64'h0000_0000_2D41_D2BF);
    write_reg(REG_AXIS_THREE_DIR, 64'hFFFF_C000_0000_0000);
    send_point({16'h8000, 16'h0000, 16'h0000, 16'h0000});
    send_point({16'h8000, 16'h0000, 16'h0000, 16'h0100});
    send_point({16'h8000, 16'h0000, 16'hFF00, 16'hFF00});
    send_point({16'h8000, 16'h0000, 16'h00B5, 16'hFE80});
    send_point({16'h8000, 16'h0100, 16'h0000, 16'h0000});
    send_point({16'h8000, 16'hFE00, 16'h0000, 16'h0000});
    send_point({16'h7FFF, 16'h0001, 16'h0020, 16'hFFE0});
    drain();

    // Saturating projections: extreme axis components.
    write_reg(REG_AXIS_ONE_DIR, 64'h0000_7FFF_7FFF_7FFF);
    write_reg(REG_AXIS_TWO_DIR, 64'hFFFF_8000_8000_8000);
    write_reg(REG_AXIS_ONE_BOUNDS, pack_bounds(-32768, 32767, -32768, 32767));
    write_reg(REG_AXIS_TWO_BOUNDS, pack_bounds(32767, -32768, 32767, -32768));
    send_point({16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_point({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_point({16'h6000, 16'h0000, 16'h0000, 16'h0001});
    drain();

    // Random phases with fresh settings; one stretch runs without idling.
    for (int phase = 0; phase < 10; phase++) begin
      quiet_mode = (phase == 4);
      for (int r = 0; r < 3; r++) begin
        write_reg(reg_idx_t'(REG_AXIS_ONE_DIR + r), random_dir());
        write_reg(reg_idx_t'(REG_AXIS_ONE_BOUNDS + r), random_bounds());
      end
      for (int k = 0; k < 65; k++) begin
        send_point(random_point());
        // Sender hold-off until all results are back.
        if (phase == 2 && k == 30) begin
          while (sb.weights_due.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      drain();
    end
    quiet_mode = 1'b0;

    repeat (40) @(posedge clk);
    $display("Sent %0d points and checked %0d weights over 13 register settings,",
             sent, taken);
    $display("covering steps, inverted ramps, saturation and random stalls.");
    if (sb.errors == 0 && sb.weights_due.size() == 0) begin
      $display("[box_region_blend_weight] OK");
    end else begin
      $display("[box_region_blend_weight] ERROR");
    end
    $finish;
  end
endmodule

FILE: box_region_blend_weight.f
rtl/core/brbw_pkg.sv
rtl/core/brbw_proj.sv
rtl/core/brbw_ramp.sv
rtl/core/brbw_div.sv
rtl/core/brbw_wmul.sv
rtl/core/box_region_blend_weight.sv
rtl/core/brbw_checker.sv
tb/sv/tb.sv
